### rtl/core/sas_pkg.sv
// ----------------------------------------------------------------------------
// sas_pkg: shared types and constants for the sprite animation sequencer
// Sizes, request codes, sequencer states and slot records.
// ----------------------------------------------------------------------------
package sas_pkg;

  localparam int NUM_SLOTS       = 16;
  localparam int NUM_DEFS        = 8;
  localparam int MAX_FRAME_COUNT = 16;
  localparam int TIME_BITS       = 16;

  localparam int SLOT_W    = $clog2(NUM_SLOTS);
  localparam int DEF_W     = $clog2(NUM_DEFS);
  localparam int FRAME_W   = $clog2(MAX_FRAME_COUNT);
  localparam int COUNT_W   = $clog2(MAX_FRAME_COUNT + 1);
  localparam int COL_DEPTH = NUM_DEFS * MAX_FRAME_COUNT;
  localparam int COL_AW    = DEF_W + FRAME_W;

  localparam int ACTION_W = 3;
  localparam int ROW_W    = 8;
  localparam int COL_W    = 8;
  localparam int STATUS_W = 2;

  typedef enum logic [ACTION_W-1:0] {
    ACT_DEF_HDR = 3'd0,
    ACT_DEF_COL = 3'd1,
    ACT_CREATE  = 3'd2,
    ACT_DESTROY = 3'd3,
    ACT_TICK    = 3'd4,
    ACT_QUERY   = 3'd5
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_UNDEF = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_QRD,
    S_FIN
  } state_e;

  typedef struct packed {
    logic                 on;
    logic                 loops;
    logic [DEF_W-1:0]     def;
    logic [FRAME_W-1:0]   frame;
    logic [TIME_BITS-1:0] rem;
  } slot_t;

  typedef struct packed {
    logic [COUNT_W-1:0]   count;
    logic [TIME_BITS-1:0] duration;
  } adv_def_t;

  typedef struct packed {
    logic [ACTION_W-1:0]  action;
    logic [DEF_W-1:0]     def_id;
    logic [SLOT_W-1:0]    slot_id;
    logic                 loop_flag;
    logic [COUNT_W-1:0]   num_frames;
    logic [TIME_BITS-1:0] duration;
    logic [ROW_W-1:0]     row;
    logic [FRAME_W-1:0]   pos;
    logic [COL_W-1:0]     col;
    logic [TIME_BITS-1:0] dt;
  } req_t;

  typedef struct packed {
    status_e            status;
    logic [SLOT_W-1:0]  slot;
    logic [ROW_W-1:0]   row;
    logic [COL_W-1:0]   col;
    logic [FRAME_W-1:0] idx;
    logic               active;
  } res_t;

endpackage

### rtl/core/sprite_animation_sequencer.sv
// ----------------------------------------------------------------------------
// sprite_animation_sequencer: animation definitions and playing slots
// Defines animations, creates and destroys slots, ticks time, answers queries.
// ----------------------------------------------------------------------------
// channel  | direction | tdata / tuser
// s_axis   | in        | request fields / action
// m_axis   | out       | response fields / status
//
// Define, destroy and unused codes go from accept straight to the response.
// Query adds a column store read. Create ends at once for an undefined
// definition, else walks the slots to the first free one; tick walks all 16
// slots through the shared advance unit.
// Reset clears all slots and the definition valid bits at once.
// A response waiting in the output register does not block the next accept.
// ----------------------------------------------------------------------------
module sprite_animation_sequencer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // def_id, slot_id, loop_flag, num_frames, frame_duration, sheet_row,
  // frame_position, sheet_column, delta_time, zero pad
  input  logic [71:0] s_axis_tdata,
  // action
  input  logic [2:0]  s_axis_tuser,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // given_slot, shown_row, shown_column, shown_index, slot_active, zero pad
  output logic [31:0] m_axis_tdata,
  // status
  output logic [1:0]  m_axis_tuser
);

  localparam logic [sas_pkg::SLOT_W-1:0] LAST_SLOT =
    sas_pkg::SLOT_W'(sas_pkg::NUM_SLOTS - 1);

  sas_pkg::state_e  state_q, state_d;
  sas_pkg::req_t    req_q;
  sas_pkg::res_t    res_q;
  sas_pkg::slot_t   slots_q [sas_pkg::NUM_SLOTS];
  sas_pkg::slot_t   cur_slot, adv_slot;
  sas_pkg::adv_def_t adv_def;

  logic                             def_valid_q [sas_pkg::NUM_DEFS];
  logic [sas_pkg::COUNT_W-1:0]      def_count_q [sas_pkg::NUM_DEFS];
  logic [sas_pkg::TIME_BITS-1:0]    def_dur_q   [sas_pkg::NUM_DEFS];
  logic [sas_pkg::ROW_W-1:0]        def_row_q   [sas_pkg::NUM_DEFS];

  logic [sas_pkg::SLOT_W-1:0]  idx_q;
  logic [sas_pkg::SLOT_W-1:0]  rd_idx;
  logic [sas_pkg::COUNT_W-1:0] clamped_count;
  logic [sas_pkg::COL_W-1:0]   col_rd_data;
  logic [sas_pkg::NUM_SLOTS-1:0] slot_on_vec;

  logic s_fire, out_free, is_tick, is_create, is_last;
  logic col_we, col_re;
  logic m_valid_q;
  logic [31:0] m_data_q;
  logic [1:0]  m_user_q;

  assign s_axis_tready = (state_q == sas_pkg::S_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign out_free      = !m_valid_q || m_axis_tready;
  assign is_tick       = (req_q.action == sas_pkg::ACT_TICK);
  assign is_create     = (req_q.action == sas_pkg::ACT_CREATE);
  assign is_last       = (idx_q == LAST_SLOT);

  assign rd_idx   = (state_q == sas_pkg::S_SCAN) ? idx_q : req_q.slot_id;
  assign cur_slot = slots_q[rd_idx];
  assign adv_def  = '{count: def_count_q[cur_slot.def], duration: def_dur_q[cur_slot.def]};

  always_comb begin
    for (int i = 0; i < sas_pkg::NUM_SLOTS; i++) begin
      slot_on_vec[i] = slots_q[i].on;
    end
  end

  always_comb begin
    clamped_count = req_q.num_frames;
    if (req_q.num_frames == '0) begin
      clamped_count = sas_pkg::COUNT_W'(1);
    end else if (req_q.num_frames > sas_pkg::COUNT_W'(sas_pkg::MAX_FRAME_COUNT)) begin
      clamped_count = sas_pkg::COUNT_W'(sas_pkg::MAX_FRAME_COUNT);
    end
  end

  sas_advance_unit u_advance (
    .slot_i (cur_slot),
    .def_i  (adv_def),
    .dt_i   (req_q.dt),
    .slot_o (adv_slot)
  );

  assign col_we = (state_q == sas_pkg::S_EXEC) && (req_q.action == sas_pkg::ACT_DEF_COL);
  assign col_re = (state_q == sas_pkg::S_EXEC) && (req_q.action == sas_pkg::ACT_QUERY);

  sas_col_mem u_col_mem (
    .clk_i     (clk_i),
    .wr_en_i   (col_we),
    .wr_addr_i ({req_q.def_id, req_q.pos}),
    .wr_data_i (req_q.col),
    .rd_en_i   (col_re),
    .rd_addr_i ({cur_slot.def, cur_slot.frame}),
    .rd_data_o (col_rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sas_pkg::S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      sas_pkg::S_IDLE: begin
        if (s_fire) state_d = sas_pkg::S_EXEC;
      end
      sas_pkg::S_EXEC: begin
        case (req_q.action)
          sas_pkg::ACT_TICK:   state_d = sas_pkg::S_SCAN;
          sas_pkg::ACT_CREATE: state_d = def_valid_q[req_q.def_id] ? sas_pkg::S_SCAN
                                                                   : sas_pkg::S_FIN;
          sas_pkg::ACT_QUERY:  state_d = sas_pkg::S_QRD;
          default:             state_d = sas_pkg::S_FIN;
        endcase
      end
      sas_pkg::S_SCAN: begin
        if (is_last || (is_create && !cur_slot.on)) state_d = sas_pkg::S_FIN;
      end
      sas_pkg::S_QRD: begin
        state_d = sas_pkg::S_FIN;
      end
      sas_pkg::S_FIN: begin
        if (out_free) state_d = sas_pkg::S_IDLE;
      end
      default: begin
        state_d = sas_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      req_q.action      <= s_axis_tuser;
      req_q.def_id      <= s_axis_tdata[2:0];
      req_q.slot_id     <= s_axis_tdata[6:3];
      req_q.loop_flag   <= s_axis_tdata[7];
      req_q.num_frames  <= s_axis_tdata[12:8];
      req_q.duration    <= s_axis_tdata[28:13];
      req_q.row         <= s_axis_tdata[36:29];
      req_q.pos         <= s_axis_tdata[40:37];
      req_q.col         <= s_axis_tdata[48:41];
      req_q.dt          <= s_axis_tdata[64:49];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (state_q == sas_pkg::S_EXEC) begin
      idx_q <= '0;
    end else if (state_q == sas_pkg::S_SCAN) begin
      idx_q <= idx_q + sas_pkg::SLOT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sas_pkg::NUM_SLOTS; i++) begin
        slots_q[i] <= '0;
      end
    end else if (state_q == sas_pkg::S_EXEC && req_q.action == sas_pkg::ACT_DESTROY) begin
      slots_q[req_q.slot_id].on <= 1'b0;
    end else if (state_q == sas_pkg::S_SCAN && cur_slot.on && is_tick) begin
      slots_q[idx_q] <= adv_slot;
    end else if (state_q == sas_pkg::S_SCAN && !cur_slot.on && is_create) begin
      slots_q[idx_q] <= '{on: 1'b1, loops: req_q.loop_flag, def: req_q.def_id,
                          frame: '0, rem: '0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sas_pkg::NUM_DEFS; i++) begin
        def_valid_q[i] <= 1'b0;
      end
    end else if (state_q == sas_pkg::S_EXEC && req_q.action == sas_pkg::ACT_DEF_HDR) begin
      def_valid_q[req_q.def_id] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sas_pkg::S_EXEC && req_q.action == sas_pkg::ACT_DEF_HDR) begin
      def_count_q[req_q.def_id] <= clamped_count;
      def_dur_q[req_q.def_id]   <= req_q.duration;
      def_row_q[req_q.def_id]   <= req_q.row;
    end
  end

  always_ff @(posedge clk_i) begin
    case (state_q)
      sas_pkg::S_IDLE: begin
        if (s_fire) res_q <= '0;
      end
      sas_pkg::S_EXEC: begin
        if (is_create && !def_valid_q[req_q.def_id]) begin
          res_q.status <= sas_pkg::ST_UNDEF;
        end
        if (req_q.action == sas_pkg::ACT_QUERY && cur_slot.on) begin
          res_q.row    <= def_row_q[cur_slot.def];
          res_q.idx    <= cur_slot.frame;
          res_q.active <= 1'b1;
        end
      end
      sas_pkg::S_SCAN: begin
        if (is_create && !cur_slot.on) begin
          res_q.slot <= idx_q;
        end else if (is_create && is_last) begin
          res_q.status <= sas_pkg::ST_FULL;
        end
      end
      sas_pkg::S_QRD: begin
        if (res_q.active) res_q.col <= col_rd_data;
      end
      default: begin
        res_q <= res_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (state_q == sas_pkg::S_FIN && out_free) begin
      m_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == sas_pkg::S_FIN && out_free) begin
      m_data_q <= {7'd0, res_q.active, res_q.idx, res_q.col, res_q.row, res_q.slot};
      m_user_q <= res_q.status;
    end
  end

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign m_axis_tuser  = m_user_q;

  a_accept_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_fire |=> state_q == sas_pkg::S_EXEC)
    else $error("accepted request did not start execution");

  a_full_means_all_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sas_pkg::S_FIN && res_q.status == sas_pkg::ST_FULL) |-> (&slot_on_vec))
    else $error("no free slot reported while a slot is inactive");

  a_create_sets_on: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == sas_pkg::S_SCAN && is_create && !cur_slot.on)
      |=> (slots_q[res_q.slot].on && res_q.status == sas_pkg::ST_OK))
    else $error("allocated slot not active");

endmodule

### rtl/core/sas_advance_unit.sv
// ----------------------------------------------------------------------------
// sas_advance_unit: shared frame advance for one slot
// Subtracts elapsed time or steps the frame, wrapping or holding at the end.
// ----------------------------------------------------------------------------
module sas_advance_unit (
  input  sas_pkg::slot_t                  slot_i,
  input  sas_pkg::adv_def_t               def_i,
  input  logic [sas_pkg::TIME_BITS-1:0]   dt_i,
  output sas_pkg::slot_t                  slot_o
);

  logic [sas_pkg::COUNT_W-1:0] next_frame;

  assign next_frame = sas_pkg::COUNT_W'(slot_i.frame) + sas_pkg::COUNT_W'(1);

  always_comb begin
    slot_o = slot_i;
    if (dt_i < slot_i.rem) begin
      slot_o.rem = slot_i.rem - dt_i;
    end else begin
      if (next_frame >= def_i.count) begin
        slot_o.frame = slot_i.loops ? '0 :
                       sas_pkg::FRAME_W'(def_i.count - sas_pkg::COUNT_W'(1));
      end else begin
        slot_o.frame = sas_pkg::FRAME_W'(next_frame);
      end
      slot_o.rem = def_i.duration;
    end
  end

endmodule

### rtl/core/sas_col_mem.sv
// ----------------------------------------------------------------------------
// sas_col_mem: sheet column store
// One column per frame of each definition; one write and one registered read.
// ----------------------------------------------------------------------------
module sas_col_mem (
  input  logic                        clk_i,
  input  logic                        wr_en_i,
  input  logic [sas_pkg::COL_AW-1:0]  wr_addr_i,
  input  logic [sas_pkg::COL_W-1:0]   wr_data_i,
  input  logic                        rd_en_i,
  input  logic [sas_pkg::COL_AW-1:0]  rd_addr_i,
  output logic [sas_pkg::COL_W-1:0]   rd_data_o
);

  logic [sas_pkg::COL_W-1:0] mem_q [sas_pkg::COL_DEPTH];
  logic [sas_pkg::COL_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
